// File: design/interval_timer_three_counter_macros.svh
// Assertion macros shared by the interval timer checker.
// No dependencies; included by bare file name.
`ifndef INTERVAL_TIMER_THREE_COUNTER_MACROS_SVH
`define INTERVAL_TIMER_THREE_COUNTER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ITT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval timer check failed");
// Next-cycle implication checked outside reset.
`define ITT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval timer check failed");
`endif

// File: design/itt_pkg.sv
// Package for the three-counter interval timer: codes and constants.
// No dependencies.
package itt_pkg;
  localparam int unsigned NumCtr = 3;
  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;
  localparam logic [2:0] PortCtrl = 3'd3;
  localparam logic [2:0] PortSys  = 3'd4;
  localparam logic [1:0] StOk          = 2'd0;
  localparam logic [1:0] StBadPort     = 2'd1;
  localparam logic [1:0] StUnsupported = 2'd2;
  localparam logic [1:0] StCountOne    = 2'd3;
  localparam logic [2:0] Mode0 = 3'd0;
  localparam logic [2:0] Mode2 = 3'd2;
  localparam logic [2:0] Mode3 = 3'd3;
  localparam logic [15:0] CntMax  = 16'hffff;
  localparam logic [15:0] CntMaxE = 16'hfffe;
endpackage

// File: design/interval_timer_three_counter.sv
// Accepts one beat per cycle while the sink does not stall.
// The input beat is registered, the three counters are updated by short
// logic and the result lands in an output register with a skid stage.
// While the sink stalls, the skid slot fills and the input stage holds its beat.
// Reset (asynchronous, active low) restores the documented counter state.
module interval_timer_three_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  port_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] tick_delta_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        irq_request_o,
  output logic        counter2_out_o,
  output logic [1:0]  status_o
);
  // Counter state, one entry per counter.
  logic [2:0]  mode_q [3];
  logic [15:0] reload_q [3], count_q [3], wasm_q [3], hold_q [3];
  logic [2:0]  wph_q, rph_q, full_q, gate_q, out_q, run_q;
  logic        spk_q, refresh_q;

  logic [2:0]  mode_d [3];
  logic [15:0] reload_d [3], count_d [3], wasm_d [3], hold_d [3];
  logic [2:0]  wph_d, rph_d, full_d, gate_d, out_d, run_d;
  logic        spk_d, refresh_d;

  // Input register stage.
  logic        in_v_q;
  logic [1:0]  op_q;
  logic [2:0]  port_q;
  logic [7:0]  wd_q;
  logic [15:0] dl_q;

  // Result register and skid register.
  logic        res_v_q, skid_v_q;
  logic [11:0] res_q, skid_q, res_new;
  logic        fire;

  // The input stage accepts a beat whenever the skid slot is free. The held beat
  // is processed only when its result has a register to land in.
  assign in_ready_o  = !skid_v_q;
  assign fire        = in_v_q && (!skid_v_q || out_ready_i);
  assign out_valid_o = res_v_q;
  assign {read_data_o, irq_request_o, counter2_out_o, status_o} = res_q;

  logic [7:0]  rd;
  logic [1:0]  st;
  logic        irq;

  always_comb begin
    logic [1:0]  c;
    logic [3:0]  cmd;
    logic [2:0]  md;
    logic [15:0] v, n, full;
    logic [16:0] d2;
    mode_d = mode_q; reload_d = reload_q; count_d = count_q;
    wasm_d = wasm_q; hold_d = hold_q;
    wph_d = wph_q; rph_d = rph_q; full_d = full_q; gate_d = gate_q;
    out_d = out_q; run_d = run_q; spk_d = spk_q; refresh_d = refresh_q;
    rd = 8'd0; st = itt_pkg::StOk; irq = 1'b0;
    c = port_q[1:0];
    cmd = wd_q[7:4];
    md = wd_q[3:1];
    v = 16'd0; n = 16'd0; full = 16'd0; d2 = 17'd0;
    if (fire) begin
      case (op_q)
        itt_pkg::OpRead: begin
          if (port_q < 3'd3) begin
            v = full_q[c] ? hold_q[c] : count_q[c];
            rd = rph_q[c] ? v[15:8] : v[7:0];
            rph_d[c] = !rph_q[c];
            if (rph_q[c]) full_d[c] = 1'b0;
          end else if (port_q == itt_pkg::PortSys) begin
            refresh_d = !refresh_q;
            rd = {2'b00, out_q[2], !refresh_q, 2'b00, spk_q, gate_q[2]};
          end else begin
            st = itt_pkg::StBadPort;
          end
        end
        itt_pkg::OpWrite: begin
          if (port_q < 3'd3) begin
            if (!wph_q[c]) begin
              wasm_d[c] = {8'd0, wd_q};
              wph_d[c] = 1'b1;
            end else begin
              full = {wd_q, wasm_q[c][7:0]};
              wasm_d[c] = full;
              wph_d[c] = 1'b0;
              reload_d[c] = full;
              full_d[c] = 1'b0;
              case (mode_q[c])
                itt_pkg::Mode0: begin
                  count_d[c] = full;
                  run_d[c] = 1'b1;
                  if (gate_q[c]) out_d[c] = 1'b0;
                end
                itt_pkg::Mode2, itt_pkg::Mode3: begin
                  if (full == 16'd1) st = itt_pkg::StCountOne;
                  if (mode_q[c] == itt_pkg::Mode3) full[0] = 1'b0;
                  reload_d[c] = full;
                  if (gate_q[c] && !run_q[c]) begin
                    count_d[c] = full;
                    run_d[c] = 1'b1;
                    out_d[c] = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end else if (port_q == itt_pkg::PortCtrl) begin
            c = cmd[3:2];
            if (cmd >= 4'd12) begin
              st = (cmd == 4'd15) ? itt_pkg::StUnsupported : itt_pkg::StOk;
            end else if (cmd[1:0] == 2'd0) begin
              if (!full_q[c]) begin
                hold_d[c] = count_q[c];
                rph_d[c] = 1'b0;
                full_d[c] = 1'b1;
              end
            end else if (cmd[1:0] == 2'd3) begin
              if (wd_q[0] || !(md == itt_pkg::Mode0 || md == itt_pkg::Mode2 ||
                               md == itt_pkg::Mode3)) begin
                st = itt_pkg::StUnsupported;
              end else begin
                mode_d[c] = md;
                wasm_d[c] = 16'd0;
                wph_d[c] = 1'b0;
              end
            end else begin
              st = itt_pkg::StUnsupported;
            end
          end else if (port_q == itt_pkg::PortSys) begin
            spk_d = wd_q[1];
            if (wd_q[0] != gate_q[2]) begin
              gate_d[2] = wd_q[0];
              if (wd_q[0]) begin
                if (mode_q[2] == itt_pkg::Mode0) begin
                  count_d[2] = reload_q[2];
                  if (run_q[2]) out_d[2] = 1'b0;
                end else if (mode_q[2] == itt_pkg::Mode2 || mode_q[2] == itt_pkg::Mode3) begin
                  run_d[2] = 1'b1;
                  out_d[2] = 1'b1;
                  count_d[2] = reload_q[2];
                end
              end else if (mode_q[2] == itt_pkg::Mode2 || mode_q[2] == itt_pkg::Mode3) begin
                run_d[2] = 1'b0;
                out_d[2] = 1'b1;
              end
            end
          end else begin
            st = itt_pkg::StBadPort;
          end
        end
        itt_pkg::OpTick: begin
          for (int i = 0; i < 3; i++) begin
            n = count_q[i];
            d2 = {dl_q, 1'b0};
            if (gate_q[i] && run_q[i]) begin
              case (mode_q[i])
                itt_pkg::Mode0: begin
                  if (n == 16'd0) count_d[i] = itt_pkg::CntMax;
                  else if (dl_q >= n) begin
                    count_d[i] = 16'd0;
                    out_d[i] = 1'b1;
                  end else count_d[i] = n - dl_q;
                end
                itt_pkg::Mode2: begin
                  if (n == 16'd0) begin
                    count_d[i] = itt_pkg::CntMax;
                    out_d[i] = 1'b1;
                  end else if (n == 16'd1) begin
                    count_d[i] = reload_q[i];
                    out_d[i] = 1'b1;
                  end else if (n == 16'd2 || dl_q >= n - 16'd1) begin
                    count_d[i] = 16'd1;
                    out_d[i] = 1'b0;
                  end else count_d[i] = n - dl_q;
                end
                itt_pkg::Mode3: begin
                  if (n == 16'd0) count_d[i] = itt_pkg::CntMaxE;
                  else if (n <= 16'd2 || d2 >= {1'b0, n}) begin
                    count_d[i] = reload_q[i];
                    out_d[i] = !out_q[i];
                  end else count_d[i] = n - d2[15:0];
                end
                default: ;
              endcase
            end
          end
          irq = !out_q[0] && out_d[0];
        end
        default: st = itt_pkg::StUnsupported;
      endcase
    end
  end

  assign res_new = {rd, irq, out_d[2], st};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      res_v_q <= 1'b0;
      skid_v_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        mode_q[i] <= itt_pkg::Mode3;
        reload_q[i] <= 16'd0; count_q[i] <= 16'd0;
        wasm_q[i] <= 16'd0; hold_q[i] <= 16'd0;
      end
      wph_q <= 3'b000; rph_q <= 3'b000; full_q <= 3'b000;
      gate_q <= 3'b011; out_q <= 3'b111; run_q <= 3'b000;
      spk_q <= 1'b0; refresh_q <= 1'b0;
    end else begin
      mode_q <= mode_d; reload_q <= reload_d; count_q <= count_d;
      wasm_q <= wasm_d; hold_q <= hold_d;
      wph_q <= wph_d; rph_q <= rph_d; full_q <= full_d; gate_q <= gate_d;
      out_q <= out_d; run_q <= run_d; spk_q <= spk_d; refresh_q <= refresh_d;
      // The input stage keeps its beat until that beat has been processed.
      if (in_valid_i && in_ready_o) in_v_q <= 1'b1;
      else if (fire) in_v_q <= 1'b0;
      // Result goes to the output register if free and the skid slot is empty, else to the skid slot.
      if (!res_v_q || out_ready_i) begin
        if (skid_v_q) begin
          res_v_q <= 1'b1;
          skid_v_q <= fire;
        end else begin
          res_v_q <= fire;
        end
      end else if (fire) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q <= opcode_i; port_q <= port_i; wd_q <= write_data_i; dl_q <= tick_delta_i;
    end
    if (!res_v_q || out_ready_i) begin
      res_q <= skid_v_q ? skid_q : res_new;
      if (skid_v_q) skid_q <= res_new;
    end else if (fire) begin
      skid_q <= res_new;
    end
  end
endmodule

// File: design/interval_timer_three_counter_chk.sv
// Port-level checker for the interval timer, bound to the top level.
// Depends on interval_timer_three_counter_macros.svh and itt_pkg.
`include "interval_timer_three_counter_macros.svh"
module interval_timer_three_counter_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o,
  input logic       irq_request_o,
  input logic [1:0] status_o
);
  // An interrupt only comes from a tick, which never returns read data.
  `ITT_ASSERT_IMP(a_irq_no_data, clk_i, rst_ni, out_valid_o && irq_request_o, read_data_o == 8'd0)
  // A tick never reports a bad port or count of one.
  `ITT_ASSERT_IMP(a_irq_ok, clk_i, rst_ni, out_valid_o && irq_request_o, status_o == itt_pkg::StOk)
  // A beat accepted into an empty block shows a result once it has passed the input and result registers.
  `ITT_ASSERT_NXT(a_result_follows, clk_i, rst_ni, in_valid_i && in_ready_o && !out_valid_o, ##1 out_valid_o)
  // A stalled result stays valid.
  `ITT_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

bind interval_timer_three_counter interval_timer_three_counter_chk u_chk (.*);
